>>> rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRI_W   = 8;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    // Operation codes on s_operation
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes on m_status
    localparam logic [STAT_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DEQ   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd3;

    // Fill level of the queue as seen by the controller
    typedef enum logic [1:0] {
        Q_EMPTY,
        Q_PART,
        Q_FULL
    } spq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture result payload for this beat
        logic insert;  // insert incoming item into the cell chain
        logic remove;  // pop the front cell
    } spq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
// Bounded queue of DEPTH entries held in a chain of registers sorted by
// ascending priority number; equal priorities leave in arrival order. Each
// beat on s_ is an enqueue or a dequeue and gives exactly one result beat on
// m_. Every cell compares its priority with the incoming one in the same
// cycle, so the block takes one beat per cycle while results are taken;
// the result sits in an output register, and the next beat is accepted in
// the cycle the waiting result is taken. An enqueue into a full
// queue is dropped with overflow status, a dequeue from an empty queue
// reports underflow. m_occupancy shows the low 5 bits of the entry count.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_operation,
    input  wire logic signed [VALUE_W-1:0] s_item_value,
    input  wire logic [PRI_W-1:0]          s_item_priority,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [STAT_W-1:0]              m_status,
    output logic signed [VALUE_W-1:0]      m_removed_value,
    output logic [PRI_W-1:0]               m_removed_priority,
    output logic [OCC_W-1:0]               m_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    spq_cmd_t      cmd;
    logic [CW-1:0] count;

    spq_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .cmd         (cmd),
        .count       (count)
    );

    spq_datapath #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_datapath (
        .aclk             (aclk),
        .cmd              (cmd),
        .count            (count),
        .in_value         (s_item_value),
        .in_priority      (s_item_priority),
        .removed_value    (m_removed_value),
        .removed_priority (m_removed_priority)
    );

endmodule

`default_nettype wire

>>> rtl/spq_datapath.sv
// Sorted cell chain and result payload registers of the priority queue.
`default_nettype none

module spq_datapath import spq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                      aclk,
    input  wire spq_cmd_t                  cmd,
    input  wire logic [CW-1:0]             count,
    input  wire logic signed [VALUE_W-1:0] in_value,
    input  wire logic [PRI_W-1:0]          in_priority,
    output logic signed [VALUE_W-1:0]      removed_value,
    output logic [PRI_W-1:0]               removed_priority
);

    logic signed [VALUE_W-1:0] val_reg  [DEPTH];
    logic [PRI_W-1:0]          pri_reg  [DEPTH];
    logic signed [VALUE_W-1:0] val_next [DEPTH];
    logic [PRI_W-1:0]          pri_next [DEPTH];
    logic [DEPTH-1:0]          ahead;   // new item goes in front of this cell

    logic signed [VALUE_W-1:0] rvalue_reg;
    logic [PRI_W-1:0]          rpri_reg;

    // Compare every held cell against the incoming priority
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ahead[i] = !((CW'(i) < count) && (pri_reg[i] <= in_priority));
        end
    end

    // Per-cell next value: keep, take new item, shift back or shift forward
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [VALUE_W-1:0] up_val;
            logic [PRI_W-1:0]          up_pri;
            logic                      take_new;

            if (gi == 0) begin : g_first
                assign take_new = 1'b1;
            end else begin : g_rest
                assign take_new = !ahead[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign up_val = val_reg[gi];
                assign up_pri = pri_reg[gi];
            end else begin : g_inner
                assign up_val = val_reg[gi+1];
                assign up_pri = pri_reg[gi+1];
            end

            always_comb begin
                val_next[gi] = val_reg[gi];
                pri_next[gi] = pri_reg[gi];
                if (cmd.insert && ahead[gi]) begin
                    if (take_new) begin
                        val_next[gi] = in_value;
                        pri_next[gi] = in_priority;
                    end else begin
                        val_next[gi] = val_reg[(gi == 0) ? 0 : gi-1];
                        pri_next[gi] = pri_reg[(gi == 0) ? 0 : gi-1];
                    end
                end else if (cmd.remove) begin
                    val_next[gi] = up_val;
                    pri_next[gi] = up_pri;
                end
            end

            always_ff @(posedge aclk) begin
                val_reg[gi] <= val_next[gi];
                pri_reg[gi] <= pri_next[gi];
            end
        end
    endgenerate

    // Capture the front cell on a dequeue, zero on other accepted beats
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rvalue_reg <= cmd.remove ? val_reg[0] : '0;
            rpri_reg   <= cmd.remove ? pri_reg[0] : '0;
        end
    end

    assign removed_value    = rvalue_reg;
    assign removed_priority = rpri_reg;

endmodule

`default_nettype wire

>>> rtl/spq_ctrl.sv
// Controller: handshake, fill-level state machine, entry count and status.
`default_nettype none

module spq_ctrl import spq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [STAT_W-1:0]       m_status,
    output logic [OCC_W-1:0]        m_occupancy,
    output spq_cmd_t                cmd,
    output logic [CW-1:0]           count
);

    spq_state_t          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                mvalid_reg, mvalid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                accept;

    assign s_ready = !mvalid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Commands and status for the accepted beat
    always_comb begin
        cmd         = '0;
        status_next = status_reg;
        count_next  = count_reg;
        cmd.load    = accept;
        if (accept) begin
            unique case (state_reg)
                Q_EMPTY: begin
                    cmd.insert  = (s_operation == OP_ENQ);
                    status_next = (s_operation == OP_ENQ) ? ST_ENQ : ST_UNDER;
                end
                Q_PART: begin
                    cmd.insert  = (s_operation == OP_ENQ);
                    cmd.remove  = (s_operation == OP_DEQ);
                    status_next = (s_operation == OP_ENQ) ? ST_ENQ : ST_DEQ;
                end
                Q_FULL: begin
                    cmd.remove  = (s_operation == OP_DEQ);
                    status_next = (s_operation == OP_ENQ) ? ST_OVER : ST_DEQ;
                end
                default: begin
                    status_next = status_reg;
                end
            endcase
            if (cmd.insert) begin
                count_next = count_reg + CW'(1);
            end else if (cmd.remove) begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    // Next fill-level state follows the updated count
    always_comb begin
        if (count_next == '0) begin
            state_next = Q_EMPTY;
        end else if (count_next == CW'(DEPTH)) begin
            state_next = Q_FULL;
        end else begin
            state_next = Q_PART;
        end
    end

    // Hold a result until the downstream side takes it
    always_comb begin
        mvalid_next = mvalid_reg;
        if (accept) begin
            mvalid_next = 1'b1;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= Q_EMPTY;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

    assign m_valid     = mvalid_reg;
    assign m_status    = status_reg;
    assign m_occupancy = OCC_W'(count_reg);
    assign count       = count_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the sorted priority queue: directed and random enqueue/dequeue traffic.
`default_nettype none

module tb_top;
    import spq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int IDLE_LIMIT  = 5000;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] value;
        logic [PRI_W-1:0]   prio;
        logic [OCC_W-1:0]   occupancy;
    } queue_result_t;

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_operation     = OP_ENQ;
    logic signed [VALUE_W-1:0] s_item_value    = '0;
    logic [PRI_W-1:0]          s_item_priority = '0;
    logic                      m_ready         = 1'b0;
    wire logic                 s_ready;
    wire logic                 m_valid;
    wire logic [STAT_W-1:0]    m_status;
    wire logic [VALUE_W-1:0]   m_removed_value;
    wire logic [PRI_W-1:0]     m_removed_priority;
    wire logic [OCC_W-1:0]     m_occupancy;

    // Mirror of the queue contents in priority order
    logic [VALUE_W-1:0] mirror_value [QDEPTH];
    logic [PRI_W-1:0]   mirror_prio  [QDEPTH];
    int unsigned        mirror_fill = 0;

    queue_result_t      expected_results [$];
    queue_result_t      head_result;
    int unsigned        error_count = 0;
    int unsigned        status_seen [4] = '{default: 0};
    int unsigned        ops_sent = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        ready_hold = 0;
    bit                 no_idling = 1'b0;

    sorted_priority_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_item_value      (s_item_value),
        .s_item_priority   (s_item_priority),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_removed_value   (m_removed_value),
        .m_removed_priority(m_removed_priority),
        .m_occupancy       (m_occupancy)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the mirror and return the result it must give
    function automatic queue_result_t apply_queue_op(logic op, logic [VALUE_W-1:0] val,
                                                     logic [PRI_W-1:0] pri);
        queue_result_t res;
        int unsigned   slot;
        res = '0;
        if (op == OP_ENQ) begin
            if (mirror_fill >= QDEPTH) begin
                res.status = ST_OVER;
            end else begin
                // land behind every entry of equal or smaller priority number
                slot = 0;
                while (slot < mirror_fill && mirror_prio[slot] <= pri)
                    slot++;
                for (int i = mirror_fill; i > slot; i--) begin
                    mirror_value[i] = mirror_value[i-1];
                    mirror_prio[i]  = mirror_prio[i-1];
                end
                mirror_value[slot] = val;
                mirror_prio[slot]  = pri;
                mirror_fill++;
                res.status = ST_ENQ;
            end
        end else if (mirror_fill == 0) begin
            res.status = ST_UNDER;
        end else begin
            res.status = ST_DEQ;
            res.value  = mirror_value[0];
            res.prio   = mirror_prio[0];
            for (int i = 1; i < mirror_fill; i++) begin
                mirror_value[i-1] = mirror_value[i];
                mirror_prio[i-1]  = mirror_prio[i];
            end
            mirror_fill--;
        end
        res.occupancy = OCC_W'(mirror_fill);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // A narrow range piles up equal priorities to exercise arrival order
    function automatic logic [PRI_W-1:0] pick_priority(bit narrow);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (narrow)
            return PRI_W'($urandom_range(0, 3));
        return PRI_W'($urandom_range(0, 255));
    endfunction

    // Send one beat after a random gap and record what it must produce
    task automatic send_op(input logic op, input logic [VALUE_W-1:0] val,
                           input logic [PRI_W-1:0] pri);
        int unsigned gap;
        gap = no_idling ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_item_value    <= val;
        s_item_priority <= pri;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_queue_op(op, val, pri));
        ops_sent++;
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic test_empty_dequeue();
        send_op(OP_DEQ, 32'hdead_beef, 8'hff);
    endtask

    task automatic test_extreme_fields();
        send_op(OP_ENQ, 32'h8000_0000, 8'd255);
        send_op(OP_ENQ, 32'h7fff_ffff, 8'd0);
        send_op(OP_ENQ, 32'hffff_ffff, 8'd128);
        send_op(OP_ENQ, 32'h0000_0001, 8'd128);
        repeat (5) send_op(OP_DEQ, $urandom, PRI_W'($urandom));
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QDEPTH; i++)
            send_op(OP_ENQ, $urandom, PRI_W'((QDEPTH - 1 - i) * 17));
        send_op(OP_ENQ, 32'h1234_5678, 8'd0);
        wait_for_drain();
    endtask

    // Bursts that lean toward filling, draining or neither
    task automatic test_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned deq_pct;
        bit          narrow;
        logic        op;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: deq_pct = 20;
                1: deq_pct = 80;
                default: deq_pct = 50;
            endcase
            narrow = ($urandom_range(0, 1) == 1);
            repeat (burst) begin
                op = ($urandom_range(0, 99) < deq_pct) ? OP_DEQ : OP_ENQ;
                send_op(op, pick_value(), pick_priority(narrow));
                sent++;
            end
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        no_idling = 1'b1;
        test_random_traffic(count);
        no_idling = 1'b0;
    endtask

    // Result channel backpressure: ready runs and stalls of random length
    always @(posedge aclk) begin
        if (no_idling) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= !m_ready;
            ready_hold <= m_ready ? pick_gap() : $urandom_range(1, 20);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, status %0d value 0x%h", $time,
                         m_status, m_removed_value);
                error_count++;
            end else begin
                head_result = expected_results.pop_front();
                status_seen[head_result.status]++;
                if (m_status !== head_result.status) begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             head_result.status, m_status);
                    error_count++;
                end
                if (m_removed_value !== head_result.value) begin
                    $display("%0t: removed_value expected 0x%h, got 0x%h", $time,
                             head_result.value, m_removed_value);
                    error_count++;
                end
                if (m_removed_priority !== head_result.prio) begin
                    $display("%0t: removed_priority expected %0d, got %0d", $time,
                             head_result.prio, m_removed_priority);
                    error_count++;
                end
                if (m_occupancy !== head_result.occupancy) begin
                    $display("%0t: occupancy expected %0d, got %0d", $time,
                             head_result.occupancy, m_occupancy);
                    error_count++;
                end
            end
        end
    end

    // Stop the run if neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                         idle_cycles, expected_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_dequeue();
        test_extreme_fields();
        test_full_queue();
        test_random_traffic(850);
        test_back_to_back(150);

        wait_for_drain();
        repeat (5) @(posedge aclk);
        $display("Sent %0d operations: %0d enqueued, %0d dequeued, %0d underflows, %0d overflows.",
                 ops_sent, status_seen[ST_ENQ], status_seen[ST_DEQ], status_seen[ST_UNDER],
                 status_seen[ST_OVER]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
